@@ rtl/adss_pkg.sv @@
package adss_pkg;

  // field and arithmetic widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IN_DATA_W = 7 * DATA_W;
  localparam int unsigned OP_W      = DATA_W + 1;
  localparam int unsigned PROD_W    = 2 * OP_W;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned DT_SHIFT  = 48;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = CFG_IDX_W'(1);
  localparam logic [DATA_W-1:0] TIME_STEP_RESET   = 32'd2814750;
  localparam logic [DATA_W-1:0] SOURCE_RATE_RESET = 32'd65536;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_L,
    S_MUL_C,
    S_MUL_R,
    S_MUL_ADV,
    S_MUL_SRC1,
    S_MUL_KDF,
    S_CAP_SRC1,
    S_MUL_SRC,
    S_MUL_L2,
    S_MUL_C2,
    S_MUL_R2,
    S_ACC_DVG,
    S_CAP_DVG,
    S_CAP_RATE,
    S_MUL_DT,
    S_ACC_DT,
    S_CAP_UPD,
    S_EMIT_A,
    S_EMIT_B,
    S_EMIT_C
  } state_e;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_L_V0,
    MUL_C_V1,
    MUL_R_V2,
    MUL_U2_DF,
    MUL_DU2_V0,
    MUL_KAP_DF,
    MUL_SRC1_ALPHA,
    MUL_L2_FW0,
    MUL_C2_FW1,
    MUL_R2_FW2,
    MUL_RATE_DT
  } mul_sel_e;

  // accumulator operations
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_RND,
    ACC_ADD,
    ACC_LOAD_DT
  } acc_op_e;

  // result capture targets
  typedef enum logic [3:0] {
    CAP_NONE,
    CAP_DF,
    CAP_ADV,
    CAP_SRC1,
    CAP_KDF,
    CAP_SRC,
    CAP_DVG,
    CAP_RATE,
    CAP_UPD
  } cap_sel_e;

  // output value select
  typedef enum logic [1:0] {
    OUT_UPD,
    OUT_VW0,
    OUT_VW1,
    OUT_VW2
  } out_sel_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    cap_sel_e cap_sel;
    logic     commit;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/adss_ctrl.sv @@
module adss_ctrl
  import adss_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_POINTS - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_UPD  = CNT_W'(4);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_eff;

  // the point at the length limit closes the sweep as well
  assign last_eff = st_i.last || (cnt_q == CNT_LAST);

  // state and point index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_MUL_L;
      S_MUL_L:    state_d = S_MUL_C;
      S_MUL_C:    state_d = S_MUL_R;
      S_MUL_R:    state_d = S_MUL_ADV;
      S_MUL_ADV:  state_d = S_MUL_SRC1;
      S_MUL_SRC1: state_d = S_MUL_KDF;
      S_MUL_KDF:  state_d = S_CAP_SRC1;
      S_CAP_SRC1: state_d = S_MUL_SRC;
      S_MUL_SRC:  state_d = S_MUL_L2;
      S_MUL_L2:   state_d = S_MUL_C2;
      S_MUL_C2:   state_d = S_MUL_R2;
      S_MUL_R2:   state_d = S_ACC_DVG;
      S_ACC_DVG:  state_d = S_CAP_DVG;
      S_CAP_DVG:  state_d = S_CAP_RATE;
      S_CAP_RATE: state_d = S_MUL_DT;
      S_MUL_DT:   state_d = S_ACC_DT;
      S_ACC_DT:   state_d = S_CAP_UPD;
      S_CAP_UPD: begin
        if (cnt_q >= CNT_TWO) state_d = S_EMIT_A;
        else if (last_eff && (cnt_q >= CNT_ONE)) state_d = S_EMIT_B;
        else if (last_eff) state_d = S_EMIT_C;
        else state_d = S_IDLE;
      end
      S_EMIT_A: begin
        if (st_i.out_free) state_d = last_eff ? S_EMIT_B : S_IDLE;
      end
      S_EMIT_B:   if (st_i.out_free) state_d = S_EMIT_C;
      S_EMIT_C:   if (st_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // point index advances, or returns to zero after the final point, when an item is finished
  always_comb begin
    cnt_d = cnt_q;
    if ((state_q != S_IDLE) && (state_d == S_IDLE)) begin
      cnt_d = last_eff ? '0 : cnt_q + CNT_ONE;
    end
  end

  // datapath commands
  always_comb begin
    cmd_o.load_in  = 1'b0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.acc_op   = ACC_HOLD;
    cmd_o.cap_sel  = CAP_NONE;
    cmd_o.commit   = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.out_sel  = OUT_VW0;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_MUL_L: cmd_o.mul_sel = MUL_L_V0;
      S_MUL_C: begin
        cmd_o.mul_sel = MUL_C_V1;
        cmd_o.acc_op  = ACC_LOAD_RND;
      end
      S_MUL_R: begin
        cmd_o.mul_sel = MUL_R_V2;
        cmd_o.acc_op  = ACC_ADD;
      end
      S_MUL_ADV: begin
        cmd_o.mul_sel = MUL_U2_DF;
        cmd_o.acc_op  = ACC_ADD;
      end
      S_MUL_SRC1: begin
        cmd_o.mul_sel = MUL_DU2_V0;
        cmd_o.cap_sel = CAP_DF;
        cmd_o.acc_op  = ACC_LOAD_RND;
      end
      S_MUL_KDF: begin
        cmd_o.mul_sel = MUL_KAP_DF;
        cmd_o.cap_sel = CAP_ADV;
        cmd_o.acc_op  = ACC_LOAD_RND;
      end
      S_CAP_SRC1: begin
        cmd_o.cap_sel = CAP_SRC1;
        cmd_o.acc_op  = ACC_LOAD_RND;
      end
      S_MUL_SRC: begin
        cmd_o.mul_sel = MUL_SRC1_ALPHA;
        cmd_o.cap_sel = CAP_KDF;
      end
      S_MUL_L2: begin
        cmd_o.mul_sel = MUL_L2_FW0;
        cmd_o.acc_op  = ACC_LOAD_RND;
      end
      S_MUL_C2: begin
        cmd_o.mul_sel = MUL_C2_FW1;
        cmd_o.cap_sel = CAP_SRC;
        cmd_o.acc_op  = ACC_LOAD_RND;
      end
      S_MUL_R2: begin
        cmd_o.mul_sel = MUL_R2_FW2;
        cmd_o.acc_op  = ACC_ADD;
      end
      S_ACC_DVG:  cmd_o.acc_op  = ACC_ADD;
      S_CAP_DVG:  cmd_o.cap_sel = CAP_DVG;
      S_CAP_RATE: cmd_o.cap_sel = CAP_RATE;
      S_MUL_DT:   cmd_o.mul_sel = MUL_RATE_DT;
      S_ACC_DT:   cmd_o.acc_op  = ACC_LOAD_DT;
      S_CAP_UPD: begin
        cmd_o.cap_sel = CAP_UPD;
        cmd_o.commit  = 1'b1;
      end
      S_EMIT_A: begin
        cmd_o.out_load = st_i.out_free;
        cmd_o.out_sel  = (cnt_q >= CNT_UPD) ? OUT_UPD : OUT_VW0;
      end
      S_EMIT_B: begin
        cmd_o.out_load = st_i.out_free;
        cmd_o.out_sel  = OUT_VW1;
      end
      S_EMIT_C: begin
        cmd_o.out_load = st_i.out_free;
        cmd_o.out_sel  = OUT_VW2;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/adss_datapath.sv @@
module adss_datapath
  import adss_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              st_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic                 in_last_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DATA_W-1:0]    out_data_o,
  output logic                 out_last_o
);

  localparam logic [ACC_W-1:0] RND_C  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_W-1:0] DT_RND = ACC_W'(1) << (DT_SHIFT - 1);

  // saturate a 34 bit sum to 32 bits
  function automatic logic [DATA_W-1:0] sat34(input logic [DATA_W+1:0] x);
    logic [DATA_W-1:0] r;
    if ((x[DATA_W+1] == x[DATA_W]) && (x[DATA_W] == x[DATA_W-1])) r = x[DATA_W-1:0];
    else if (x[DATA_W+1]) r = {1'b1, {(DATA_W-1){1'b0}}};
    else r = {1'b0, {(DATA_W-1){1'b1}}};
    return r;
  endfunction

  // configuration
  logic        [DATA_W-1:0] ts_q;
  logic signed [DATA_W-1:0] sr_q;

  // value window and incoming point
  logic signed [DATA_W-1:0] vw0_q, vw1_q, vw2_q;
  logic signed [DATA_W-1:0] h_l_q, h_c_q, h_r_q, h_u_q, h_kap_q, h_du_q;
  logic                     last_q;

  // previous point and the one before
  logic signed [DATA_W-1:0] p_l_q, p_c_q, p_r_q, p_u_q, p_kap_q, p_du_q;
  logic signed [DATA_W-1:0] q_l_q, q_c_q, q_r_q, q_u_q, q_du_q;

  // intermediate terms
  logic signed [DATA_W-1:0] df_q, fw0_q, fw1_q, fw2_q;
  logic signed [DATA_W-1:0] adv_q, src1_q, src_q, dvg_q, rate_q, upd_q;

  // shared multiplier and accumulator
  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  prod_ext, acc_d, acc_q, acc_sh;
  logic signed [DATA_W-1:0] rs;
  logic signed [DATA_W+1:0] rate_sum, upd_sum;

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q, out_sel_val;
  logic              out_last_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TIME_STEP_RESET;
      sr_q <= SOURCE_RATE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TIME_STEP) ts_q <= cfg_data_i;
      else if (cfg_index_i == CFG_SOURCE_RATE) sr_q <= cfg_data_i;
    end
  end

  // input request capture and window shift
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      vw0_q   <= vw1_q;
      vw1_q   <= vw2_q;
      vw2_q   <= in_data_i[0*DATA_W +: DATA_W];
      h_l_q   <= in_data_i[1*DATA_W +: DATA_W];
      h_c_q   <= in_data_i[2*DATA_W +: DATA_W];
      h_r_q   <= in_data_i[3*DATA_W +: DATA_W];
      h_u_q   <= in_data_i[4*DATA_W +: DATA_W];
      h_kap_q <= in_data_i[5*DATA_W +: DATA_W];
      h_du_q  <= in_data_i[6*DATA_W +: DATA_W];
      last_q  <= in_last_i;
    end
    if (cmd_i.commit) begin
      p_l_q   <= h_l_q;
      p_c_q   <= h_c_q;
      p_r_q   <= h_r_q;
      p_u_q   <= h_u_q;
      p_kap_q <= h_kap_q;
      p_du_q  <= h_du_q;
      q_l_q   <= p_l_q;
      q_c_q   <= p_c_q;
      q_r_q   <= p_r_q;
      q_u_q   <= p_u_q;
      q_du_q  <= p_du_q;
    end
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      MUL_L_V0:       begin op_a = OP_W'(p_l_q);   op_b = OP_W'(vw0_q); end
      MUL_C_V1:       begin op_a = OP_W'(p_c_q);   op_b = OP_W'(vw1_q); end
      MUL_R_V2:       begin op_a = OP_W'(p_r_q);   op_b = OP_W'(vw2_q); end
      MUL_U2_DF:      begin op_a = OP_W'(q_u_q);   op_b = OP_W'(df_q);  end
      MUL_DU2_V0:     begin op_a = OP_W'(q_du_q);  op_b = OP_W'(vw0_q); end
      MUL_KAP_DF:     begin op_a = OP_W'(p_kap_q); op_b = OP_W'(df_q);  end
      MUL_SRC1_ALPHA: begin op_a = OP_W'(src1_q);  op_b = OP_W'(sr_q);  end
      MUL_L2_FW0:     begin op_a = OP_W'(q_l_q);   op_b = OP_W'(fw0_q); end
      MUL_C2_FW1:     begin op_a = OP_W'(q_c_q);   op_b = OP_W'(fw1_q); end
      MUL_R2_FW2:     begin op_a = OP_W'(q_r_q);   op_b = OP_W'(fw2_q); end
      MUL_RATE_DT:    begin op_a = OP_W'(rate_q);  op_b = {1'b0, ts_q}; end
      default: ;
    endcase
  end

  assign prod_d   = op_a * op_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // accumulator with the rounding offset preloaded
  always_comb begin
    acc_d = acc_q;
    case (cmd_i.acc_op)
      ACC_LOAD_RND: acc_d = prod_ext + RND_C;
      ACC_ADD:      acc_d = acc_q + prod_ext;
      ACC_LOAD_DT:  acc_d = prod_ext + DT_RND;
      default:      acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // rounded and saturated accumulator value
  always_comb begin
    acc_sh = acc_q >>> FRAC_BITS;
    if (!acc_sh[ACC_W-1] && (|acc_sh[ACC_W-2:DATA_W-1])) begin
      rs = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (acc_sh[ACC_W-1] && !(&acc_sh[ACC_W-2:DATA_W-1])) begin
      rs = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      rs = acc_sh[DATA_W-1:0];
    end
  end

  assign rate_sum = (DATA_W+2)'(adv_q) + (DATA_W+2)'(dvg_q) - (DATA_W+2)'(src_q);
  assign upd_sum  = (DATA_W+2)'(vw0_q) + (DATA_W+2)'(acc_q >>> DT_SHIFT);

  // term capture
  always_ff @(posedge clk_i) begin
    case (cmd_i.cap_sel)
      CAP_DF:   df_q   <= rs;
      CAP_ADV:  adv_q  <= rs;
      CAP_SRC1: src1_q <= rs;
      CAP_KDF: begin
        fw0_q <= fw1_q;
        fw1_q <= fw2_q;
        fw2_q <= rs;
      end
      CAP_SRC:  src_q  <= rs;
      CAP_DVG:  dvg_q  <= rs;
      CAP_RATE: rate_q <= sat34(rate_sum);
      CAP_UPD:  upd_q  <= sat34(upd_sum);
      default: ;
    endcase
  end

  // result select
  always_comb begin
    case (cmd_i.out_sel)
      OUT_UPD: out_sel_val = upd_q;
      OUT_VW0: out_sel_val = vw0_q;
      OUT_VW1: out_sel_val = vw1_q;
      OUT_VW2: out_sel_val = vw2_q;
      default: out_sel_val = vw0_q;
    endcase
  end

  // output register, freed when the receiver takes the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= out_sel_val;
      out_last_q <= (cmd_i.out_sel == OUT_VW2);
    end
  end

  assign st_o.last     = last_q;
  assign st_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;
  assign out_last_o    = out_last_q;

endmodule

@@ rtl/advection_diffusion_stencil_step_core.sv @@
// One explicit time step of a 1D advection-diffusion-source equation on a
// non-uniform grid, Q16.16 fixed point with saturation.
// Grid points arrive in order on the s_axis channel; the final point of a
// sweep carries s_axis_tlast. Updated values leave on the m_axis channel in
// point order, m_axis_tlast marking the final point. Time step and source
// rate are written through the cfg channel; the user must write them only
// while the block is idle, as the block itself does not enforce it. A point
// is accepted only in the idle state; a sequencer then steps through its
// states on one shared 33x33 multiplier with accumulator (eleven products),
// so a new point is taken only once the sequencer is back in idle. The result
// of point i leaves once point i+2 is in; the final point also flushes the
// two held ones, so an item gives up to three results. The two points at
// each end of a sweep pass through unchanged.
// Each result waits in an output register; while the receiver stalls the
// sequencer holds before loading the next result, and the last result of
// an item may wait there while the next point is accepted.
// Reset clears the point index and the output valid and restores the
// register defaults; window contents are refilled by each sweep.
module advection_diffusion_stencil_step_core
  import adss_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // f_old, coef_left, coef_center, coef_right, velocity, diffusivity,
  // velocity_gradient, 32 bits each
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,   // last_point
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,   // f_new
  output logic                 m_axis_tlast,   // sweep_done
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready_o = 1'b1;

  // sequencer
  adss_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  // arithmetic and windows
  adss_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule
